FILE: src/bcgd_pkg.sv
`default_nettype none

package bcgd_pkg;

    // Result codes carried on the event channel
    typedef enum logic [1:0] {
        EV_NONE        = 2'd0,
        EV_SINGLE      = 2'd1,
        EV_DOUBLE      = 2'd2,
        EV_LONG_PRESS  = 2'd3
    } event_code_t;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    localparam cfg_addr_t CFG_LONG_PRESS   = 1'd0;
    localparam cfg_addr_t CFG_DOUBLE_CLICK = 1'd1;

    // Configuration register width and reset values
    localparam int unsigned CFG_DATA_W = 16;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    localparam cfg_data_t LONG_PRESS_RESET   = 16'd2000;
    localparam cfg_data_t DOUBLE_CLICK_RESET = 16'd300;

    // Button level encoding (active low)
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

endpackage

`default_nettype wire

FILE: src/bcgd_if.sv
`default_nettype none

// Tick channel: one sampled button level per transaction
interface bcgd_tick_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

// Event channel: one result code per tick
interface bcgd_event_if;
    import bcgd_pkg::*;
    logic        valid;
    logic        ready;
    event_code_t event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

// Configuration write channel
interface bcgd_cfg_if;
    import bcgd_pkg::*;
    logic      valid;
    logic      ready;
    cfg_addr_t addr;
    cfg_data_t data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

FILE: src/button_click_gesture_detector_top.sv
// Button gesture detector. Each tick transaction carries one millisecond
// sample of an active-low button and yields exactly one event transaction:
// none, single click, double click or long press. A long press is reported
// once when the hold reaches long_press_ticks; a short release pairs with a
// pending click within double_click_ticks (double click) or becomes the
// pending click, and a pending click older than the window reports a single
// click. The block takes one tick per clock cycle: the gesture state updates
// on acceptance and the result sits in an output register, so a new tick is
// accepted whenever that register is empty or being drained in the same
// cycle. Configuration writes (index 0 long_press_ticks, index 1
// double_click_ticks) are always accepted and should be made while idle.
// TIMER_BITS sets the width of the two saturating timers.
`default_nettype none

module button_click_gesture_detector_top
    import bcgd_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 16
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    bcgd_tick_if.sink         tick,
    bcgd_event_if.source      evt,
    bcgd_cfg_if.sink          cfg
);

    // Compare width covers both the timers and the 16-bit limits
    localparam int unsigned CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [CMP_W-1:0]      cmp_t;

    // Configuration registers
    cfg_data_t long_press_ticks_reg;
    cfg_data_t double_click_ticks_reg;

    // Gesture state
    logic   prev_level_reg, prev_level_next;
    timer_t press_age_reg, press_age_next;
    logic   long_done_reg, long_done_next;
    logic   click_pending_reg, click_pending_next;
    timer_t gap_age_reg, gap_age_next;

    // Output register
    logic        evt_valid_reg;
    event_code_t event_code_reg;
    event_code_t event_code_next;

    logic tick_accept;
    logic expired;
    logic press_edge;
    logic release_edge;
    cmp_t long_limit;
    cmp_t gap_limit;

    assign cfg.ready   = 1'b1;
    assign tick.ready  = !evt_valid_reg || evt.ready;
    assign tick_accept = tick.valid && tick.ready;
    assign evt.valid      = evt_valid_reg;
    assign evt.event_code = event_code_reg;

    assign long_limit = cmp_t'(long_press_ticks_reg);
    assign gap_limit  = cmp_t'(double_click_ticks_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ticks_reg   <= LONG_PRESS_RESET;
            double_click_ticks_reg <= DOUBLE_CLICK_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.addr)
                CFG_LONG_PRESS:   long_press_ticks_reg   <= cfg.data;
                CFG_DOUBLE_CLICK: double_click_ticks_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // One tick of gesture logic
    always_comb
    begin
        prev_level_next    = tick.button_level;
        long_done_next     = long_done_reg;
        click_pending_next = click_pending_reg;
        event_code_next    = EV_NONE;

        // Saturating timers advance first
        press_age_next = press_age_reg;
        if (prev_level_reg == LEVEL_PRESSED && press_age_reg != '1)
            press_age_next = press_age_reg + 1'b1;
        gap_age_next = gap_age_reg;
        if (click_pending_reg && gap_age_reg != '1)
            gap_age_next = gap_age_reg + 1'b1;
        expired = click_pending_reg && (cmp_t'(gap_age_next) > gap_limit);

        press_edge   = (tick.button_level == LEVEL_PRESSED) && (prev_level_reg == LEVEL_RELEASED);
        release_edge = (tick.button_level == LEVEL_RELEASED) && (prev_level_reg == LEVEL_PRESSED);

        if (press_edge)
        begin
            press_age_next = '0;
            long_done_next = 1'b0;
        end

        // Release: late long press, double click, or new pending click
        if (release_edge && !long_done_next)
        begin
            if (cmp_t'(press_age_next) >= long_limit)
            begin
                event_code_next = EV_LONG_PRESS;
                long_done_next  = 1'b1;
            end
            else if (click_pending_reg && !expired)
            begin
                event_code_next    = EV_DOUBLE;
                click_pending_next = 1'b0;
                gap_age_next       = '0;
            end
            else
            begin
                if (click_pending_reg)
                    event_code_next = EV_SINGLE;
                click_pending_next = 1'b1;
                gap_age_next       = '0;
            end
        end

        // Hold reaching the limit
        if (tick.button_level == LEVEL_PRESSED && !long_done_next
            && cmp_t'(press_age_next) >= long_limit)
        begin
            event_code_next = EV_LONG_PRESS;
            long_done_next  = 1'b1;
        end

        // Pending click timed out, reported only when nothing else fired
        if (event_code_next == EV_NONE && click_pending_next
            && cmp_t'(gap_age_next) > gap_limit)
        begin
            event_code_next    = EV_SINGLE;
            click_pending_next = 1'b0;
            gap_age_next       = '0;
        end
    end

    // State update on each tick transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg    <= LEVEL_RELEASED;
            press_age_reg     <= '0;
            long_done_reg     <= 1'b0;
            click_pending_reg <= 1'b0;
            gap_age_reg       <= '0;
        end
        else if (tick_accept)
        begin
            prev_level_reg    <= prev_level_next;
            press_age_reg     <= press_age_next;
            long_done_reg     <= long_done_next;
            click_pending_reg <= click_pending_next;
            gap_age_reg       <= gap_age_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_valid_reg <= 1'b0;
        else if (tick_accept)
            evt_valid_reg <= 1'b1;
        else if (evt.ready)
            evt_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (tick_accept)
            event_code_reg <= event_code_next;
    end

endmodule

`default_nettype wire

FILE: src/bcgd_checker.sv
`default_nettype none

module bcgd_checker
    import bcgd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        tick_valid,
    input wire logic        tick_ready,
    input wire logic        tick_level,
    input wire logic        evt_valid,
    input wire logic        evt_ready,
    input wire event_code_t evt_code
);

    // A stalled event transaction holds its code
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt_code))
        else $error("event changed while stalled");

    // Every accepted tick produces an event in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> evt_valid)
        else $error("tick produced no event");

    // An empty output register never blocks the tick channel
    assert property (@(posedge clk) disable iff (!rst_n)
        !evt_valid |-> tick_ready)
        else $error("tick stalled with output empty");

    // A double click only comes from a release sample
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready && tick_level == LEVEL_PRESSED |=> evt_code != EV_DOUBLE)
        else $error("double click on a pressed sample");

endmodule

bind button_click_gesture_detector_top bcgd_checker u_bcgd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .tick_level (tick.button_level),
    .evt_valid  (evt.valid),
    .evt_ready  (evt.ready),
    .evt_code   (evt.event_code)
);

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bcgd_pkg::*;

    localparam int unsigned RESET_CYCLES   = 10;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned RAND_PER_PHASE = 270;
    localparam int unsigned RECONFIG_EVERY = 100;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned TIMER_W        = 16;

    typedef enum {ROW_TICK, ROW_CFG} row_op_e;

    // One line of the directed table; a tick row repeats its level reps times
    typedef struct {
        row_op_e     op;
        logic        lvl;
        int unsigned reps;
        cfg_addr_t   addr;
        cfg_data_t   data;
        bit          typed;
        event_code_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bcgd_tick_if  tick_ch ();
    bcgd_event_if evt_ch ();
    bcgd_cfg_if   cfg_ch ();

    button_click_gesture_detector_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_ch),
        .evt   (evt_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the gesture state and its two limits
    cfg_data_t          long_limit    = LONG_PRESS_RESET;
    cfg_data_t          dbl_window    = DOUBLE_CLICK_RESET;
    logic               btn_prev      = LEVEL_RELEASED;
    logic [TIMER_W-1:0] hold_age      = '0;
    logic [TIMER_W-1:0] gap_age       = '0;
    bit                 hold_reported = 1'b0;
    bit                 click_waiting = 1'b0;

    event_code_t expected_events[$];
    stim_row_t   dir_rows[$];
    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned ticks_sent   = 0;
    int unsigned src_idle_pct = 37;
    int unsigned snk_idle_pct = 55;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Advance the shadow state by one tick and return the event it reports
    function automatic event_code_t predict_gesture_event(logic lvl);
        event_code_t ev;
        bit          expired;
        ev = EV_NONE;
        if (btn_prev == LEVEL_PRESSED && hold_age != '1)
            hold_age = hold_age + 1'b1;
        if (click_waiting && gap_age != '1)
            gap_age = gap_age + 1'b1;
        expired = click_waiting && (gap_age > dbl_window);

        // press edge starts a new hold
        if (lvl == LEVEL_PRESSED && btn_prev == LEVEL_RELEASED) begin
            hold_age      = '0;
            hold_reported = 1'b0;
        end

        // release of a hold that was not yet reported as long
        if (lvl == LEVEL_RELEASED && btn_prev == LEVEL_PRESSED && !hold_reported) begin
            if (hold_age >= long_limit) begin
                ev            = EV_LONG_PRESS;
                hold_reported = 1'b1;
            end else if (click_waiting && !expired) begin
                ev            = EV_DOUBLE;
                click_waiting = 1'b0;
                gap_age       = '0;
            end else begin
                if (click_waiting)
                    ev = EV_SINGLE;
                click_waiting = 1'b1;
                gap_age       = '0;
            end
        end

        if (lvl == LEVEL_PRESSED && !hold_reported && hold_age >= long_limit) begin
            ev            = EV_LONG_PRESS;
            hold_reported = 1'b1;
        end

        // a stale pending click reports only on a tick with nothing else
        if (ev == EV_NONE && click_waiting && gap_age > dbl_window) begin
            ev            = EV_SINGLE;
            click_waiting = 1'b0;
            gap_age       = '0;
        end

        btn_prev = lvl;
        return ev;
    endfunction

    function automatic stim_row_t tick_row(logic lvl, int unsigned reps, bit typed = 1'b0,
                                           event_code_t want = EV_NONE);
        stim_row_t r;
        r.op    = ROW_TICK;
        r.lvl   = lvl;
        r.reps  = reps;
        r.addr  = CFG_LONG_PRESS;
        r.data  = '0;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(cfg_addr_t addr, cfg_data_t data);
        stim_row_t r;
        r       = tick_row(LEVEL_RELEASED, 0);
        r.op    = ROW_CFG;
        r.addr  = addr;
        r.data  = data;
        return r;
    endfunction

    // Limit values: mostly small, now and then an extreme
    function automatic cfg_data_t pick_limit(int unsigned hi);
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return cfg_data_t'(1);
            2:       return '1;
            default: return cfg_data_t'($urandom_range(hi, 2));
        endcase
    endfunction

    // Drive one tick transaction; record its event once accepted
    task automatic send_tick(logic lvl, bit typed = 1'b0, event_code_t want = EV_NONE);
        event_code_t ev;
        @(negedge clk);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.button_level <= lvl;
        do @(posedge clk); while (!tick_ch.ready);
        ev = predict_gesture_event(lvl);
        expected_events.push_back(typed ? want : ev);
        ticks_sent++;
    endtask

    // Stop sending and wait until every pending event has arrived
    task automatic drain_events();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_addr_t addr, cfg_data_t data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        if (addr == CFG_LONG_PRESS)
            long_limit = data;
        else
            dbl_window = data;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Event sink back-pressure
    always @(negedge clk)
        evt_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);

    // Event checker
    always @(posedge clk) begin : event_check
        event_code_t want;
        if (rst_n && evt_ch.valid && evt_ch.ready) begin
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected event transaction: code %0d", evt_ch.event_code);
            end else begin
                want = expected_events.pop_front();
                if (evt_ch.event_code !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("event_code mismatch: expected %0d, got %0d",
                                 want, evt_ch.event_code);
                end
            end
        end
    end

    // Watchdog: too many cycles with no transaction on any channel
    always @(posedge clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (evt_ch.valid && evt_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t   row;
        int unsigned phase_end;
        int unsigned next_cfg_at;
        int unsigned cap;
        int unsigned dur;

        rst_n                = 1'b0;
        tick_ch.valid        = 1'b0;
        tick_ch.button_level = LEVEL_RELEASED;
        cfg_ch.valid         = 1'b0;
        cfg_ch.addr          = CFG_LONG_PRESS;
        cfg_ch.data          = '0;

        // Directed table, reset limits first
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 3, 1'b1, EV_NONE));
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 1));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 1));
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 2));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 1));     // double click
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 1));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 311));   // single on timeout
        // shorter hold limit: long press, then a quiet release
        dir_rows.push_back(cfg_row(CFG_LONG_PRESS, 16'd20));
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 21));     // long press
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 1));     // release after long: quiet
        // zero hold limit: long press on the press tick itself
        dir_rows.push_back(cfg_row(CFG_LONG_PRESS, '0));
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 1, 1'b1, EV_LONG_PRESS));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 1));
        // short release exactly when the pending click expires
        dir_rows.push_back(cfg_row(CFG_LONG_PRESS, 16'd10));
        dir_rows.push_back(cfg_row(CFG_DOUBLE_CLICK, 16'd10));
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 1));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 2));
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 9));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 1));
        // long press and expiry on one tick, single follows a tick later
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 12));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 1));
        // limit lowered mid-hold: long press reported on release
        dir_rows.push_back(cfg_row(CFG_LONG_PRESS, 16'd100));
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 5));
        dir_rows.push_back(cfg_row(CFG_LONG_PRESS, 16'd3));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 1));
        // top limits: the window never closes and a hold turns long only once its timer saturates
        dir_rows.push_back(cfg_row(CFG_LONG_PRESS, '1));
        dir_rows.push_back(cfg_row(CFG_DOUBLE_CLICK, '1));
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 1));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 1));
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 50));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 1));      // never expired: double
        dir_rows.push_back(tick_row(LEVEL_PRESSED, 1));
        dir_rows.push_back(tick_row(LEVEL_RELEASED, 1));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.op == ROW_CFG) begin
                drain_events();
                write_reg(row.addr, row.data);
            end else begin
                repeat (row.reps) send_tick(row.lvl, row.typed, row.want);
            end
        end

        // Random gestures in three phases of differing idling, limits reshuffled now and then
        for (int ph = 0; ph < 3; ph++) begin
            drain_events();
            src_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 55 : 0;
            snk_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 37 : 0;
            phase_end    = ticks_sent + RAND_PER_PHASE;
            next_cfg_at  = ticks_sent;
            while (ticks_sent < phase_end) begin
                if (ticks_sent >= next_cfg_at) begin
                    drain_events();
                    write_reg(CFG_LONG_PRESS, pick_limit(40));
                    write_reg(CFG_DOUBLE_CLICK, pick_limit(30));
                    next_cfg_at = ticks_sent + RECONFIG_EVERY;
                end
                if ($urandom_range(9, 0) < 2) begin
                    // noise: bouncing levels
                    repeat ($urandom_range(8, 1)) send_tick(logic'($urandom_range(1, 0)));
                end else begin
                    // press then release, sized around the current limits
                    cap = (long_limit > 40) ? 40 : long_limit;
                    dur = $urandom_range(cap + 3, 1);
                    repeat (dur) send_tick(LEVEL_PRESSED);
                    cap = (dbl_window > 30) ? 30 : dbl_window;
                    dur = $urandom_range(cap + 4, 1);
                    repeat (dur) send_tick(LEVEL_RELEASED);
                end
            end
        end

        drain_events();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_events.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
src/bcgd_pkg.sv
src/bcgd_if.sv
src/button_click_gesture_detector_top.sv
src/bcgd_checker.sv
sim/tb_top.sv
